>>> src/iira_pkg.sv
package iira_pkg;

	localparam int CAPACITY   = 16;
	localparam int WORD_WIDTH = 32;

	// Port widths fixed by the request and result formats
	localparam int MODE_W  = 3;
	localparam int IDX_W   = 5;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	// Internal widths that follow from CAPACITY
	localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	typedef logic [WORD_WIDTH-1:0] word_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [CMP_W-1:0]      cmp_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_GET    = 3'd0,
		MODE_SET    = 3'd1,
		MODE_SWAP   = 3'd2,
		MODE_INSERT = 3'd3,
		MODE_REMOVE = 3'd4
	} mode_t;

	// Broadcast to every cell of the row
	typedef struct packed {
		logic  en;      // commit the operation this cycle
		mode_t mode;
		cmp_t  idx;
		cmp_t  idx2;
		cmp_t  count;   // fill count before the operation
		word_t value;   // word to write
		word_t word_a;  // word held at idx
		word_t word_b;  // word held at idx2
	} cell_ctrl_t;

endpackage

>>> src/indexed_insert_remove_array_unit.sv
// Indexed insert/remove array: an ordered list of up to 16 words and its
// length, held in a row of cells that shift in parallel.
//
// Request channel (in_valid / in_stall): mode, index, second_index, value.
// Modes are get, set, swap, insert and remove. A request is taken at a
// rising edge with in_valid high and in_stall low.
// Result channel (out_valid / out_stall): ok, read_value, count. Exactly one
// result per request, in request order.
//
// The result of a request is registered at the edge that takes it.
// Throughput is one request per cycle while the receiver does not stall;
// every cell updates in the same cycle, and insert and remove move each
// cell by one place from its neighbor, so the shift adds no wait.
//
// When the receiver stalls, the result register holds and in_stall rises,
// so no request is taken until the result leaves.
//
// Reset clears the length and the result valid flag. The cell words are
// not cleared; a cell is read only after it has been written.
module indexed_insert_remove_array_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [iira_pkg::MODE_W-1:0]   mode,
	input  logic [iira_pkg::IDX_W-1:0]    index,
	input  logic [iira_pkg::IDX_W-1:0]    second_index,
	input  logic [iira_pkg::VALUE_W-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          ok,
	output logic [iira_pkg::VALUE_W-1:0]  read_value,
	output logic [iira_pkg::COUNT_W-1:0]  count
);
	import iira_pkg::*;

	cnt_t       fill_q;
	logic       out_valid_q;
	logic       ok_q;
	logic [VALUE_W-1:0] read_value_q;
	logic [COUNT_W-1:0] count_q;

	cell_ctrl_t ctrl;
	word_t      words [CAPACITY];
	word_t      taps_a [CAPACITY];
	word_t      taps_b [CAPACITY];
	word_t      rd_a;
	word_t      rd_b;

	logic       accept;
	logic       ok_d;
	cnt_t       fill_d;
	mode_t      mode_e;
	cmp_t       idx_x;
	cmp_t       idx2_x;
	cmp_t       fill_x;
	logic       idx_in;
	logic       idx2_in;

	// Hold requests while a result waits on a stalled receiver
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign mode_e = mode_t'(mode);
	assign idx_x  = cmp_t'(index);
	assign idx2_x = cmp_t'(second_index);
	assign fill_x = cmp_t'(fill_q);
	assign idx_in  = idx_x < fill_x;
	assign idx2_in = idx2_x < fill_x;

	// Decide success and the new length
	always_comb begin
		ok_d   = 1'b0;
		fill_d = fill_q;
		case (mode_e)
			MODE_GET, MODE_SET: ok_d = idx_in;
			MODE_SWAP:          ok_d = idx_in && idx2_in && (idx_x != idx2_x);
			MODE_INSERT: begin
				ok_d = (idx_x <= fill_x) && (fill_q < cnt_t'(CAPACITY));
				if (ok_d) fill_d = fill_q + cnt_t'(1);
			end
			MODE_REMOVE: begin
				ok_d = idx_in;
				if (ok_d) fill_d = fill_q - cnt_t'(1);
			end
			default: ok_d = 1'b0;
		endcase
	end

	// OR the addressed taps into the two read buses
	always_comb begin
		rd_a = '0;
		rd_b = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_a = rd_a | taps_a[i];
			rd_b = rd_b | taps_b[i];
		end
	end

	assign ctrl.en     = accept && ok_d;
	assign ctrl.mode   = mode_e;
	assign ctrl.idx    = idx_x;
	assign ctrl.idx2   = idx2_x;
	assign ctrl.count  = fill_x;
	assign ctrl.value  = word_t'(value);
	assign ctrl.word_a = rd_a;
	assign ctrl.word_b = rd_b;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (g == 0) begin : g_first
			assign left_w = ctrl.value;
		end else begin : g_mid_l
			assign left_w = words[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = words[g];
		end else begin : g_mid_r
			assign right_w = words[g+1];
		end
		iira_cell u_cell (
			.clk        (clk),
			.pos        (pos_t'(g)),
			.ctrl       (ctrl),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[g]),
			.tap_a      (taps_a[g]),
			.tap_b      (taps_b[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q         <= ok_d;
			read_value_q <= (ok_d && mode_e == MODE_GET) ? VALUE_W'(rd_a) : '0;
			count_q      <= COUNT_W'(fill_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign read_value = read_value_q;
	assign count      = count_q;

endmodule

>>> src/iira_cell.sv
module iira_cell (
	input  logic                clk,
	input  iira_pkg::pos_t      pos,
	input  iira_pkg::cell_ctrl_t ctrl,
	input  iira_pkg::word_t     left_word,
	input  iira_pkg::word_t     right_word,
	output iira_pkg::word_t     word,
	output iira_pkg::word_t     tap_a,
	output iira_pkg::word_t     tap_b
);
	import iira_pkg::*;

	word_t word_q;
	word_t word_d;
	cmp_t  pos_x;
	logic  hit_a;
	logic  hit_b;

	assign pos_x = cmp_t'(pos);
	assign hit_a = (pos_x == ctrl.idx);
	assign hit_b = (pos_x == ctrl.idx2);

	// Drive the shared read buses only when addressed
	assign tap_a = hit_a ? word_q : '0;
	assign tap_b = hit_b ? word_q : '0;
	assign word  = word_q;

	always_comb begin
		word_d = word_q;
		if (ctrl.en) begin
			case (ctrl.mode)
				MODE_SET: begin
					if (hit_a) word_d = ctrl.value;
				end
				MODE_SWAP: begin
					if (hit_a) word_d = ctrl.word_b;
					else if (hit_b) word_d = ctrl.word_a;
				end
				MODE_INSERT: begin
					// take the left neighbor to open a gap at idx
					if (hit_a) word_d = ctrl.value;
					else if (pos_x > ctrl.idx && pos_x <= ctrl.count) word_d = left_word;
				end
				MODE_REMOVE: begin
					// close the gap: take the right neighbor below the old top
					if (pos_x >= ctrl.idx && (pos_x + cmp_t'(1)) < ctrl.count)
						word_d = right_word;
				end
				default: word_d = word_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

endmodule

>>> src/iira_checker.sv
module iira_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          ok,
	input logic [iira_pkg::VALUE_W-1:0]  read_value,
	input logic [iira_pkg::COUNT_W-1:0]  count
);
	import iira_pkg::*;

	// Requests stall only behind a stalled, waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without a waiting result");

	// Every taken request shows a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("taken request produced no result");

	// A rejected request reads nothing
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (read_value == '0))
		else $error("rejected request returned a nonzero word");

	// The length never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= COUNT_W'(CAPACITY)))
		else $error("length above capacity");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(ok)
			&& $stable(read_value) && $stable(count)))
		else $error("stalled result changed");

endmodule

bind indexed_insert_remove_array_unit iira_checker u_iira_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.ok         (ok),
	.read_value (read_value),
	.count      (count)
);
